>>> hw/rtl/settable_clock_with_display_scan_top_macros.svh
// Assertion macros used by the checker file of the settable clock.
`ifndef SETTABLE_CLOCK_WITH_DISPLAY_SCAN_TOP_MACROS_SVH
`define SETTABLE_CLOCK_WITH_DISPLAY_SCAN_TOP_MACROS_SVH

// A property that is checked only while reset is low.
`define SCLK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is also checked during reset.
`define SCLK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sclk_pkg.sv
// Types, constants and digit helpers of the settable clock.
package sclk_pkg;

  typedef logic [5:0] scan_t;
  typedef logic [1:0] unit_t;
  typedef logic [6:0] seg_t;

  localparam scan_t KEY_LEFT  = 6'b000001;
  localparam scan_t KEY_ENTER = 6'b000010;
  localparam scan_t KEY_ESC   = 6'b000100;
  localparam scan_t KEY_RIGHT = 6'b001000;
  localparam scan_t KEY_UP    = 6'b010000;
  localparam scan_t KEY_DOWN  = 6'b100000;

  localparam scan_t DIG_SEC_ONES  = 6'b000001;
  localparam scan_t DIG_SEC_TENS  = 6'b000010;
  localparam scan_t DIG_MIN_ONES  = 6'b000100;
  localparam scan_t DIG_MIN_TENS  = 6'b001000;
  localparam scan_t DIG_HOUR_ONES = 6'b010000;
  localparam scan_t DIG_HOUR_TENS = 6'b100000;

  localparam unit_t UNIT_SEC  = 2'd0;
  localparam unit_t UNIT_MIN  = 2'd1;
  localparam unit_t UNIT_HOUR = 2'd2;

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  localparam logic [7:0] INNER_RESET = 8'd240;
  localparam logic [7:0] OUTER_RESET = 8'd4;
  localparam logic [4:0] HOUR_RESET  = 5'd23;
  localparam logic [5:0] MIN_RESET   = 6'd59;
  localparam logic [5:0] SEC_RESET   = 6'd37;

  // Tens digit of a six-bit value, by threshold compares.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] base;
    logic [5:0] diff;
    base = 6'(tens_of(v)) * 6'd10;
    diff = v - base;
    return diff[3:0];
  endfunction

  function automatic seg_t seg_of(input logic [3:0] d);
    seg_t s;
    case (d)
      4'd0: s = 7'b0111111;
      4'd1: s = 7'b0000110;
      4'd2: s = 7'b1011011;
      4'd3: s = 7'b1001111;
      4'd4: s = 7'b1100110;
      4'd5: s = 7'b1101101;
      4'd6: s = 7'b1111101;
      4'd7: s = 7'b0000111;
      4'd8: s = 7'b1111111;
      4'd9: s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/settable_clock_with_display_scan_top.sv
// Settable HH:MM:SS clock with six-digit display scan and keypad handling.
//
//   channel  signals                          payload
//   in       in_valid / in_ready              key_sense
//   out      out_valid / out_ready            digit_select .. seconds_now
//   cfg      cfg_write_en (no handshake)      cfg_index, cfg_data
//
// One scan tick is taken per cycle unless the output stalls; the output register
// takes its result on acceptance. A tick is accepted whenever the output register
// is empty or is being read in the same cycle, so a stalled output stalls input.
// Reset is synchronous, holds in_ready low while it is high, and restores the
// clock to 23:59:37 with default reloads.
module settable_clock_with_display_scan_top
  import sclk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       key_sense,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] digit_select,
  output logic [6:0] segments,
  output logic       edit_lamp,
  output logic       editing,
  output logic [1:0] edited_unit,
  output logic [4:0] hours_now,
  output logic [5:0] minutes_now,
  output logic [5:0] seconds_now
);

  logic [7:0] inner_reload, outer_reload;
  logic [7:0] inner_count, outer_count;
  logic [7:0] inner_count_next, outer_count_next;
  logic [4:0] hours_count, hours_count_next;
  logic [5:0] minutes_count, minutes_count_next;
  logic [5:0] seconds_count, seconds_count_next;
  scan_t      scan_bit, scan_bit_next, last_key, last_key_next;
  logic       press_latched, press_latched_next;
  logic       edit_on, edit_on_next;
  unit_t      unit_choice, unit_choice_next;
  logic       lamp_level, lamp_level_next;
  scan_t      sel;
  seg_t       seg;
  logic [7:0] inner_dec, outer_dec;
  logic       accept;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (scan_bit)
      DIG_SEC_ONES: begin
        sel = DIG_SEC_ONES;
        seg = seg_of(ones_of(seconds_count));
      end
      DIG_SEC_TENS: begin
        sel = DIG_SEC_TENS;
        seg = seg_of({1'b0, tens_of(seconds_count)});
      end
      DIG_MIN_ONES: begin
        sel = DIG_MIN_ONES;
        seg = seg_of(ones_of(minutes_count));
      end
      DIG_MIN_TENS: begin
        sel = DIG_MIN_TENS;
        seg = seg_of({1'b0, tens_of(minutes_count)});
      end
      DIG_HOUR_ONES: begin
        sel = DIG_HOUR_ONES;
        seg = seg_of(ones_of({1'b0, hours_count}));
      end
      default: begin
        sel = DIG_HOUR_TENS;
        seg = seg_of({1'b0, tens_of({1'b0, hours_count})});
      end
    endcase
    scan_bit_next = sel[5] ? DIG_SEC_ONES : {sel[4:0], 1'b0};
  end

  always_comb begin
    inner_count_next   = inner_count;
    outer_count_next   = outer_count;
    hours_count_next   = hours_count;
    minutes_count_next = minutes_count;
    seconds_count_next = seconds_count;
    last_key_next      = last_key;
    press_latched_next = press_latched;
    edit_on_next       = edit_on;
    unit_choice_next   = unit_choice;
    lamp_level_next    = lamp_level;
    inner_dec          = inner_count - 8'd1;
    outer_dec          = outer_count - 8'd1;

    // Prescaler and time advance.
    inner_count_next = inner_dec;
    if (inner_dec == 8'd0) begin
      outer_count_next = outer_dec;
      if (outer_dec == 8'd0) begin
        outer_count_next = outer_reload;
        if (!edit_on) begin
          if (seconds_count >= SEC_MAX) begin
            seconds_count_next = '0;
            if (minutes_count >= MIN_MAX) begin
              minutes_count_next = '0;
              hours_count_next = (hours_count >= HOUR_MAX) ? '0 : hours_count + 5'd1;
            end else begin
              minutes_count_next = minutes_count + 6'd1;
            end
          end else begin
            seconds_count_next = seconds_count + 6'd1;
          end
        end
      end
      inner_count_next = inner_reload;
    end

    // Keypad.
    if (key_sense) begin
      last_key_next = scan_bit_next;
      if (!press_latched) begin
        press_latched_next = 1'b1;
        unique case (scan_bit_next)
          KEY_ESC: begin
            lamp_level_next = 1'b0;
            edit_on_next = 1'b1;
          end
          KEY_ENTER: begin
            lamp_level_next = 1'b1;
            if (edit_on) begin
              inner_count_next = inner_reload;
              outer_count_next = outer_reload;
              edit_on_next = 1'b0;
              unit_choice_next = UNIT_SEC;
            end
          end
          KEY_LEFT: begin
            if (edit_on) begin
              unit_choice_next = (unit_choice >= UNIT_HOUR) ? UNIT_SEC : unit_choice + 2'd1;
            end
          end
          KEY_RIGHT: begin
            if (edit_on) begin
              unit_choice_next = (unit_choice == UNIT_SEC || unit_choice > UNIT_HOUR) ?
                                 UNIT_HOUR : unit_choice - 2'd1;
            end
          end
          KEY_UP: begin
            if (edit_on) begin
              unique case (unit_choice)
                UNIT_SEC: seconds_count_next = (seconds_count_next >= SEC_MAX) ?
                                               '0 : seconds_count_next + 6'd1;
                UNIT_MIN: minutes_count_next = (minutes_count_next >= MIN_MAX) ?
                                               '0 : minutes_count_next + 6'd1;
                UNIT_HOUR: hours_count_next = (hours_count_next >= HOUR_MAX) ?
                                              '0 : hours_count_next + 5'd1;
                default: ;
              endcase
            end
          end
          KEY_DOWN: begin
            if (edit_on) begin
              unique case (unit_choice)
                UNIT_SEC: seconds_count_next = (seconds_count_next == '0) ?
                                               SEC_MAX : seconds_count_next - 6'd1;
                UNIT_MIN: minutes_count_next = (minutes_count_next == '0) ?
                                               MIN_MAX : minutes_count_next - 6'd1;
                UNIT_HOUR: hours_count_next = (hours_count_next == '0) ?
                                              HOUR_MAX : hours_count_next - 5'd1;
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
    end else if (press_latched && last_key == scan_bit_next) begin
      press_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_reload  <= INNER_RESET;
      outer_reload  <= OUTER_RESET;
      inner_count   <= INNER_RESET;
      outer_count   <= OUTER_RESET;
      hours_count   <= HOUR_RESET;
      minutes_count <= MIN_RESET;
      seconds_count <= SEC_RESET;
      scan_bit      <= DIG_SEC_ONES;
      last_key      <= '0;
      press_latched <= 1'b0;
      edit_on       <= 1'b0;
      unit_choice   <= UNIT_SEC;
      lamp_level    <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index) outer_reload <= cfg_data;
        else inner_reload <= cfg_data;
      end
      if (accept) begin
        inner_count   <= inner_count_next;
        outer_count   <= outer_count_next;
        hours_count   <= hours_count_next;
        minutes_count <= minutes_count_next;
        seconds_count <= seconds_count_next;
        scan_bit      <= scan_bit_next;
        last_key      <= last_key_next;
        press_latched <= press_latched_next;
        edit_on       <= edit_on_next;
        unit_choice   <= unit_choice_next;
        lamp_level    <= lamp_level_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digit_select <= sel;
      segments     <= seg;
      edit_lamp    <= lamp_level_next;
      editing      <= edit_on_next;
      edited_unit  <= unit_choice_next;
      hours_now    <= hours_count_next;
      minutes_now  <= minutes_count_next;
      seconds_now  <= seconds_count_next;
    end
  end

endmodule

>>> hw/rtl/sclk_checker.sv
// Port-level checker for the settable clock and its bind to the top level.
`include "settable_clock_with_display_scan_top_macros.svh"

module sclk_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] digit_select,
  input logic       edit_lamp,
  input logic       editing,
  input logic [1:0] edited_unit,
  input logic [4:0] hours_now,
  input logic [5:0] minutes_now,
  input logic [5:0] seconds_now
);

  `SCLK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(digit_select), "output item changed while stalled")
  `SCLK_ASSERT(a_digit_onehot, out_valid |-> $onehot(digit_select), "digit select is not one-hot")
  `SCLK_ASSERT(a_time_range, out_valid |-> hours_now <= 5'd23 && minutes_now <= 6'd59 && seconds_now <= 6'd59, "time out of range")
  `SCLK_ASSERT(a_edit_lamp, out_valid && editing |-> !edit_lamp, "lamp lit in set mode")
  `SCLK_ASSERT(a_unit_idle, out_valid && !editing |-> edited_unit == 2'd0, "unit chosen outside set mode")

endmodule

bind settable_clock_with_display_scan_top sclk_checker u_sclk_checker (.*);
